@@ rtl/core/cle_pkg.sv @@
// ============================================================================
// cle_pkg - console line editor shared types and codes
// Transfer payload structs, request/result codes and character constants.
// ============================================================================
package cle_pkg;

    // request modes
    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    // transmit kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_BYTE  = 3'd1;
    localparam logic [2:0] KIND_ERASE = 3'd2;
    localparam logic [2:0] KIND_BELL  = 3'd3;
    localparam logic [2:0] KIND_CRLF  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_LINE = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_CTRL_U = 8'h15;
    localparam logic [7:0] CH_CTRL_W = 8'h17;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam int ERASE_W = 7;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]         tx_kind;
        logic [7:0]         tx_byte;
        logic [ERASE_W-1:0] erase_count;
        logic [7:0]         read_byte;
        logic [1:0]         status;
    } t_out;

    // whitespace: HT..CR and space
    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

endpackage

@@ rtl/core/cle_ram.sv @@
// ============================================================================
// cle_ram - simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/console_line_editor.sv @@
// ============================================================================
// console_line_editor - serial console line editor on a ring buffer
// Builds one edited input line in a DEPTH-entry ring store, hands it out
// byte by byte, and formats transmit bytes.
// ============================================================================
// One request is taken at a time and each gives exactly one result. Plain
// received bytes, editing keys other than Ctrl-W, and transmit bytes go
// from idle straight to the finish state; a line read passes through one
// RAM read state; Ctrl-W walks the word backwards through the store's
// single read port one entry per cycle until a blank stops the walk or
// the line empties. The result sits in an output register, so the next
// request is accepted while a finished result still waits to be taken.
// Backspace/DEL on an empty line rings the bell; a plain byte on a full
// line (DEPTH-1 characters, one entry is kept for the newline) rings the
// bell and is dropped; CR stores LF and marks the line ready, and received
// bytes are refused until the line has been read out. The store has no
// reset: only entries written since reset are ever read.
// ============================================================================
module console_line_editor #(
    parameter int DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cle_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cle_pkg::t_out o_out_data
);

    import cle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
    localparam logic [AW-1:0] WRAP_ADD = AW'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH - 1);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WORD,
        S_FIN
    } t_state;

    t_state         r_state;
    logic [AW-1:0]  r_rp;
    logic [AW-1:0]  r_wp;
    logic [CW-1:0]  r_cnt;
    logic           r_ready;
    t_out           r_res;     // result being built
    t_out           r_out;     // output register
    logic           r_ovalid;

    logic           in_xfer;
    logic           rx_store;
    logic [AW-1:0]  wp_prev;
    logic [AW-1:0]  wp_prev2;
    logic [AW-1:0]  wp_next;
    logic [AW-1:0]  rp_next;
    logic [AW:0]    wp_diff;
    logic [AW-1:0]  wp_clear;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    function automatic logic [AW-1:0] prev_ix(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IX : i - AW'(1);
    endfunction

    function automatic logic [AW-1:0] next_ix(input logic [AW-1:0] i);
        return (i == LAST_IX) ? '0 : i + AW'(1);
    endfunction

    // result word with no read byte
    function automatic t_out make_res(input logic [2:0]         kind,
                                      input logic [7:0]         txb,
                                      input logic [ERASE_W-1:0] ecnt,
                                      input logic [1:0]         st);
        t_out res;
        res             = '0;
        res.tx_kind     = kind;
        res.tx_byte     = txb;
        res.erase_count = ecnt;
        res.status      = st;
        return res;
    endfunction

    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign wp_prev  = prev_ix(r_wp);
    assign wp_prev2 = prev_ix(wp_prev);
    assign wp_next  = next_ix(r_wp);
    assign rp_next  = next_ix(r_rp);

    // Ctrl-U rewind: wp - cnt modulo DEPTH (cnt < DEPTH while editing)
    assign wp_diff  = {1'b0, r_wp} - {1'b0, r_cnt[AW-1:0]};
    assign wp_clear = wp_diff[AW] ? (wp_diff[AW-1:0] + WRAP_ADD) : wp_diff[AW-1:0];

    // Store write: CR (as LF) always fits, other plain bytes only below full
    always_comb begin
        rx_store = 1'b0;
        if (in_xfer && (i_in_data.mode == MODE_RX) && !r_ready) begin
            if (i_in_data.data_byte == CH_CR) begin
                rx_store = 1'b1;
            end else if ((i_in_data.data_byte != CH_BS) &&
                         (i_in_data.data_byte != CH_DEL) &&
                         (i_in_data.data_byte != CH_CTRL_W) &&
                         (i_in_data.data_byte != CH_CTRL_U) &&
                         (r_cnt < FULL_CNT)) begin
                rx_store = 1'b1;
            end
        end
    end

    assign ram_wdata = (i_in_data.data_byte == CH_CR) ? CH_LF : i_in_data.data_byte;

    // Read address: the word walk looks one entry further back each cycle,
    // a line read fetches at the read pointer, Ctrl-W starts at the last byte
    always_comb begin
        if (r_state == S_WORD) begin
            ram_raddr = wp_prev2;
        end else if (i_in_data.mode == MODE_READ) begin
            ram_raddr = r_rp;
        end else begin
            ram_raddr = wp_prev;
        end
    end

    // Writes happen only on accept in idle; any read of that entry comes
    // later, only after S_FIN, so no forwarding is needed.
    cle_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (rx_store),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_cnt    <= '0;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // S_FIN reloads the output register itself
            if (r_ovalid && !i_out_stall && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in_data.mode)
                            MODE_RX: begin
                                if (r_ready) begin
                                    r_res   <= make_res(KIND_NONE, CH_NUL, '0, ST_REFUSED);
                                    r_state <= S_FIN;
                                end else if (i_in_data.data_byte == CH_CR) begin
                                    r_wp    <= wp_next;
                                    r_cnt   <= r_cnt + ONE_CNT;
                                    r_ready <= 1'b1;
                                    r_res   <= make_res(KIND_CRLF, CH_NUL, '0, ST_OK);
                                    r_state <= S_FIN;
                                end else if ((i_in_data.data_byte == CH_BS) ||
                                             (i_in_data.data_byte == CH_DEL)) begin
                                    r_state <= S_FIN;
                                    if (r_cnt == '0) begin
                                        r_res <= make_res(KIND_BELL, CH_NUL, '0, ST_OK);
                                    end else begin
                                        r_wp  <= wp_prev;
                                        r_cnt <= r_cnt - ONE_CNT;
                                        r_res <= make_res(KIND_ERASE, CH_NUL,
                                                          ERASE_W'(1), ST_OK);
                                    end
                                end else if (i_in_data.data_byte == CH_CTRL_W) begin
                                    r_res <= '0;
                                    if (r_cnt != '0) begin
                                        r_state <= S_WORD;
                                    end else begin
                                        r_state <= S_FIN;
                                    end
                                end else if (i_in_data.data_byte == CH_CTRL_U) begin
                                    r_state <= S_FIN;
                                    if (r_cnt != '0) begin
                                        r_wp  <= wp_clear;
                                        r_cnt <= '0;
                                        r_res <= make_res(KIND_ERASE, CH_NUL,
                                                          ERASE_W'(r_cnt), ST_OK);
                                    end else begin
                                        r_res <= '0;
                                    end
                                end else if (r_cnt >= FULL_CNT) begin
                                    r_res   <= make_res(KIND_BELL, CH_NUL, '0, ST_OK);
                                    r_state <= S_FIN;
                                end else begin
                                    r_wp    <= wp_next;
                                    r_cnt   <= r_cnt + ONE_CNT;
                                    r_res   <= make_res(KIND_BYTE, i_in_data.data_byte,
                                                        '0, ST_OK);
                                    r_state <= S_FIN;
                                end
                            end
                            MODE_READ: begin
                                if (!r_ready || (r_cnt == '0)) begin
                                    r_res   <= make_res(KIND_NONE, CH_NUL, '0, ST_NO_LINE);
                                    r_state <= S_FIN;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= S_READ;
                                end
                            end
                            MODE_TX: begin
                                r_state <= S_FIN;
                                if (i_in_data.data_byte == CH_LF) begin
                                    r_res <= make_res(KIND_CRLF, CH_NUL, '0, ST_OK);
                                end else if (i_in_data.data_byte != CH_NUL) begin
                                    r_res <= make_res(KIND_BYTE, i_in_data.data_byte,
                                                      '0, ST_OK);
                                end else begin
                                    r_res <= '0;
                                end
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // pop one line byte; draining the line re-opens editing
                    r_res.read_byte <= ram_rdata;
                    r_rp            <= rp_next;
                    r_cnt           <= r_cnt - ONE_CNT;
                    if (r_cnt == ONE_CNT) begin
                        r_ready <= 1'b0;
                    end
                    r_state <= S_FIN;
                end
                S_WORD: begin
                    // ram_rdata is the entry just before the write pointer
                    if (is_blank(ram_rdata)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_wp  <= wp_prev;
                        r_cnt <= r_cnt - ONE_CNT;
                        r_res <= make_res(KIND_ERASE, CH_NUL,
                                          r_res.erase_count + ERASE_W'(1), ST_OK);
                        if (r_cnt == ONE_CNT) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("character count exceeds store depth");

    a_ready_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_cnt != '0))
        else $error("line ready with empty store");

    a_edit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ready |-> (r_cnt < CW'(DEPTH)))
        else $error("editing line has no room for newline");

    a_word_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WORD) |-> (r_cnt != '0))
        else $error("word erase walking an empty line");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input transfer did not start processing");
`endif

endmodule

@@ dv/console_line_editor_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// console_line_editor_tb - self-checking bench for the console line editor
// Feeds received, read, transmit and unused requests through the valid/stall
// input channel, tracks the line store in a local model and checks every
// result transfer in order. Both channels idle at random, and the output
// side also holds off once for a long stretch.
// ============================================================================
module console_line_editor_tb;
    import cle_pkg::*;

    localparam int         LINE_DEPTH  = 128;
    localparam int         LINE_AW     = $clog2(LINE_DEPTH);
    localparam int         ITEMS       = 1450;
    localparam int         CALM_FROM   = 700;   // no idling between these counts
    localparam int         CALM_TO     = 900;
    localparam int         HOLD_AT     = 400;   // results taken before the long hold-off
    localparam int         HOLD_CYCLES = 300;
    localparam int         PAUSE_AT    = 1100;  // sender drains the block here
    localparam int         DRAIN       = 200;   // covers a full-line word erase
    localparam int         MAX_REPORTS = 10;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    console_line_editor #(
        .DEPTH(LINE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Line editor model: ring store, pointers, character count, ready flag
    // ------------------------------------------------------------------------
    logic [7:0] line_mem [LINE_DEPTH];
    int         rd_ix     = 0;
    int         wr_ix     = 0;
    int         n_chars   = 0;
    bit         line_done = 1'b0;

    t_in  req_q [$];    // requests still to be offered
    t_out edit_q [$];   // results owed by the block, oldest first

    int n_sent    = 0;
    int n_recv    = 0;
    int n_errors  = 0;
    bit in_fire   = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Applies one request to the model and returns the result it must give.
    function automatic t_out edit_line(input t_in req);
        t_out       res;
        logic [7:0] c;
        logic [7:0] tail;
        int         prev;
        res = '0;
        c   = req.data_byte;
        case (req.mode)
            MODE_RX: begin
                if (line_done) begin
                    res.status = ST_REFUSED;
                end else if (c == CH_CR) begin
                    // newline always fits: one entry is kept free for it
                    line_mem[LINE_AW'(wr_ix)] = CH_LF;
                    wr_ix                     = (wr_ix + 1) % LINE_DEPTH;
                    n_chars++;
                    line_done   = 1'b1;
                    res.tx_kind = KIND_CRLF;
                end else if (c == CH_BS || c == CH_DEL) begin
                    if (n_chars == 0) begin
                        res.tx_kind = KIND_BELL;
                    end else begin
                        wr_ix = (wr_ix + LINE_DEPTH - 1) % LINE_DEPTH;
                        n_chars--;
                        res.tx_kind     = KIND_ERASE;
                        res.erase_count = ERASE_W'(1);
                    end
                end else if (c == CH_CTRL_W || c == CH_CTRL_U) begin
                    // Ctrl-U empties the line, Ctrl-W stops at a blank
                    while (n_chars > 0) begin
                        prev = (wr_ix + LINE_DEPTH - 1) % LINE_DEPTH;
                        tail = line_mem[LINE_AW'(prev)];
                        if (c == CH_CTRL_W &&
                            ((tail >= CH_TAB && tail <= CH_CR) || tail == CH_SPACE))
                            break;
                        wr_ix = prev;
                        n_chars--;
                        res.erase_count = res.erase_count + ERASE_W'(1);
                    end
                    if (res.erase_count != 0)
                        res.tx_kind = KIND_ERASE;
                end else if (n_chars >= LINE_DEPTH - 1) begin
                    res.tx_kind = KIND_BELL;
                end else begin
                    line_mem[LINE_AW'(wr_ix)] = c;
                    wr_ix                     = (wr_ix + 1) % LINE_DEPTH;
                    n_chars++;
                    res.tx_kind = KIND_BYTE;
                    res.tx_byte = c;
                end
            end
            MODE_READ: begin
                if (!line_done || n_chars == 0) begin
                    res.status = ST_NO_LINE;
                end else begin
                    res.read_byte = line_mem[LINE_AW'(rd_ix)];
                    rd_ix         = (rd_ix + 1) % LINE_DEPTH;
                    n_chars--;
                    if (n_chars == 0)
                        line_done = 1'b0;
                end
            end
            MODE_TX: begin
                // a zero byte terminates the string, LF goes out as CR LF
                if (c == CH_LF) begin
                    res.tx_kind = KIND_CRLF;
                end else if (c != CH_NUL) begin
                    res.tx_kind = KIND_BYTE;
                    res.tx_byte = c;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic add_req(input logic [1:0] mode, input logic [7:0] data);
        t_in req;
        req.mode      = mode;
        req.data_byte = data;
        req_q.push_back(req);
    endtask

    // One typed character: mostly letters and blanks, some editing keys,
    // some raw bytes. Without edits, editing keys and CR are kept out.
    function automatic logic [7:0] text_byte(input bit edits);
        int         r;
        int         b;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 45) begin
            c = 8'h61 + 8'($urandom_range(25));
        end else if (r < 60) begin
            b = $urandom_range(4);
            c = (b == 4) ? CH_SPACE : CH_TAB + 8'(b);   // HT, LF, VT, FF
        end else if (edits && r < 64) begin
            c = CH_BS;
        end else if (edits && r < 66) begin
            c = CH_DEL;
        end else if (edits && r < 71) begin
            c = CH_CTRL_W;
        end else if (edits && r < 72) begin
            c = CH_CTRL_U;
        end else begin
            c = 8'($urandom_range(255));
            if (!edits && (c == CH_BS || c == CH_DEL || c == CH_CTRL_W ||
                           c == CH_CTRL_U || c == CH_CR))
                c = 8'h7E;
        end
        return c;
    endfunction

    // Type a line, end it with CR, poke it while ready, then read it out.
    // A few lines are left unterminated or only partly read.
    task automatic add_line(input int len, input bit edits);
        int i;
        int r;
        int n_rd;
        for (i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 2)
                add_req(MODE_TX, CH_NUL);
            else if (r < 4)
                add_req(MODE_TX, CH_LF);
            else if (r < 9)
                add_req(MODE_TX, 8'($urandom_range(255)));
            add_req(MODE_RX, text_byte(edits));
        end
        if ($urandom_range(99) < 92)
            add_req(MODE_RX, CH_CR);
        for (i = $urandom_range(2); i > 0; i--)
            add_req(MODE_RX, 8'($urandom_range(255)));
        n_rd = ($urandom_range(99) < 90) ? len + 1 + $urandom_range(2)
                                         : $urandom_range(len);
        for (i = 0; i < n_rd; i++)
            add_req(MODE_READ, 8'($urandom_range(255)));
    endtask

    initial begin
        int r;
        // directed: empty-line edits, word and line erase, refusal, drain
        add_req(MODE_READ, 8'hFF);      // no ready line
        add_req(MODE_RX, CH_BS);        // bell on empty line
        add_req(MODE_RX, CH_DEL);
        add_req(MODE_RX, CH_CTRL_W);    // nothing to erase
        add_req(MODE_RX, CH_CTRL_U);
        add_req(MODE_RX, 8'h61);
        add_req(MODE_RX, CH_NUL);       // zero is stored and echoed
        add_req(MODE_RX, CH_LF);        // so is LF
        add_req(MODE_RX, CH_SPACE);
        add_req(MODE_RX, 8'h62);
        add_req(MODE_RX, 8'h63);
        add_req(MODE_RX, CH_CTRL_W);    // stops at the space
        add_req(MODE_RX, CH_DEL);
        add_req(MODE_RX, CH_BS);
        add_req(MODE_RX, 8'hFF);
        add_req(MODE_RX, CH_CTRL_U);
        add_req(MODE_RX, 8'h78);
        add_req(MODE_RX, CH_CR);
        add_req(MODE_RX, 8'h79);        // refused while the line is ready
        add_req(MODE_READ, 8'h00);
        add_req(MODE_READ, 8'h00);      // drains the line
        add_req(MODE_READ, 8'h00);
        add_req(MODE_TX, CH_NUL);
        add_req(MODE_TX, CH_LF);
        add_req(MODE_TX, 8'hFF);
        add_req(MODE_UNUSED, 8'hFF);

        // one line typed past full, then a random mix of lines and noise
        add_line(140, 1'b0);
        while (req_q.size() < ITEMS) begin
            r = $urandom_range(99);
            if (r < 4) begin
                add_line($urandom_range(120, 140), 1'b0);
            end else if (r < 14) begin
                add_line($urandom_range(20, 60), 1'b1);
            end else if (r < 22) begin
                for (int i = $urandom_range(1, 10); i > 0; i--)
                    add_req(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                add_line($urandom_range(16), 1'b1);
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (edit_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: offers the next request once the current one has transferred
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive
        bit skip;
        skip = (n_sent < CALM_FROM || n_sent >= CALM_TO) && ($urandom_range(99) < 30);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            // at PAUSE_AT the sender waits for every owed result
            if (req_q.size() != 0 && !skip &&
                !(n_sent == PAUSE_AT && edit_q.size() != 0)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= req_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side stall: random, plus one long hold-off that backs up the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && n_recv >= HOLD_AT) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= (n_recv < CALM_FROM || n_recv >= CALM_TO) &&
                           ($urandom_range(99) < 30);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: model each accepted request, check each result in order
    // ------------------------------------------------------------------------
    task automatic log_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            edit_q.push_back(edit_line(i_in_data));
            n_sent <= n_sent + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_recv <= n_recv + 1;
            if (edit_q.size() == 0) begin
                log_error($sformatf("result %0d arrived with none owed", n_recv));
            end else begin
                want = edit_q.pop_front();
                if (o_out_data.tx_kind     !== want.tx_kind     ||
                    o_out_data.tx_byte     !== want.tx_byte     ||
                    o_out_data.erase_count !== want.erase_count ||
                    o_out_data.read_byte   !== want.read_byte   ||
                    o_out_data.status      !== want.status)
                    log_error($sformatf({"result %0d: exp kind %0d byte %h erase %0d ",
                        "read %h st %0d, got kind %0d byte %h erase %0d read %h st %0d"},
                        n_recv, want.tx_kind, want.tx_byte, want.erase_count,
                        want.read_byte, want.status, o_out_data.tx_kind,
                        o_out_data.tx_byte, o_out_data.erase_count,
                        o_out_data.read_byte, o_out_data.status));
            end
        end
    end

endmodule
